>>> rtl/core/sic_pkg.sv
// sic_pkg: shared types and constants of the sphere inlier classifier
// no dependencies; imported by every module of the block

package sic_pkg;

    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int RAD_W      = 2 * DIFF_W;
    localparam int ROOT_W     = DIFF_W;
    localparam int RADIUS_W   = 23;
    localparam int THRESH_W   = 25;
    localparam int TALLY_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int ROOT_CNT_W = 5;

    localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } t_in_item;

    typedef struct packed {
        logic [THRESH_W-1:0] surface_distance;
        logic                is_inlier;
        logic [TALLY_W-1:0]  inlier_total;
        logic                end_of_cloud;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT_GO,
        S_ROOT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       sq_en;
        logic       sq_first;
        logic [1:0] sq_sel;
        logic       sum_en;
        logic       root_start;
        logic       finish;
    } t_ctrl;

endpackage

>>> rtl/core/sic_sqrt.sv
// sic_sqrt: digit-by-digit integer square root, one result bit per cycle
// depends on sic_pkg

module sic_sqrt
    import sic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]      r_rad, n_rad;
    logic [ROOT_W+1:0]     r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [ROOT_W+1:0] w_rem_sh;
    logic [ROOT_W+1:0] w_trial;
    logic              w_fit;

    // bring down the next two radicand bits, try root*4+1
    assign w_rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_comb begin
        n_rad  = {r_rad[RAD_W-3:0], 2'b00};
        n_rem  = w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
        n_root = {r_root[ROOT_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ROOT_CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/core/sic_ctrl.sv
// sic_ctrl: sequencer that steps one point through square, sum, root and finish
// depends on sic_pkg

module sic_ctrl
    import sic_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_root_done,
    input  logic  i_out_free,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    t_state     r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SQUARE;
                    n_sel   = AXIS_X;
                end
            end
            S_SQUARE: begin
                n_sel = r_sel + 1'b1;
                if (r_sel == AXIS_Z) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:     n_state = S_ROOT_GO;
            S_ROOT_GO: n_state = S_ROOT;
            S_ROOT: begin
                if (i_root_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl            = '0;
        o_ctrl.sq_sel     = r_sel;
        o_ctrl.sq_first   = (r_sel == AXIS_X);
        o_busy            = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:    o_ctrl.load       = i_in_valid;
            S_SQUARE:  o_ctrl.sq_en      = 1'b1;
            S_SUM:     o_ctrl.sum_en     = 1'b1;
            S_ROOT_GO: o_ctrl.root_start = 1'b1;
            S_ROOT:    o_ctrl.finish     = 1'b0;
            S_DONE:    o_ctrl.finish     = i_out_free;
            default:   o_ctrl.finish     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= AXIS_X;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

>>> rtl/core/sphere_inlier_classifier_unit.sv
// sphere_inlier_classifier_unit: takes a new point only once the previous one has finished:
// one shared 25x25 multiplier squares the three axes in turn, then a bit-serial root unit
// works out the distance
// the finished result sits in an output register, so a new point may enter while it waits
// synchronous active-low reset clears the configuration registers, the sequencer, the tally and the output valid flag
// depends on sic_pkg, sic_ctrl, sic_sqrt

module sphere_inlier_classifier_unit
    import sic_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [RADIUS_W-1:0]       r_radius;
    logic [THRESH_W-1:0]       r_thresh;
    logic [TALLY_W-1:0]        r_tally;

    t_in_item          r_pt;
    logic [RAD_W-1:0]  r_prod;
    logic [RAD_W-1:0]  r_acc;
    t_out_item         r_out;
    logic              r_out_valid;

    t_ctrl             w_ctrl;
    logic              w_busy;
    logic              w_out_free;
    logic              w_root_done;
    logic [ROOT_W-1:0] w_root;

    logic signed [COORD_W-1:0] w_p, w_c;
    logic signed [DIFF_W-1:0]  w_d;
    logic [DIFF_W-1:0]         w_mag;
    logic [RAD_W-1:0]          w_sq;

    logic [ROOT_W-1:0]   w_rad_ext;
    logic [THRESH_W-1:0] w_dist;
    logic                w_inl;
    logic [TALLY_W-1:0]  w_tally_next;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_busy;

    sic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_root_done (w_root_done),
        .i_out_free  (w_out_free),
        .o_busy      (w_busy),
        .o_ctrl      (w_ctrl)
    );

    sic_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctrl.root_start),
        .i_radicand (r_acc),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= '0;
            r_thresh <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_cx     <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Y: r_cy     <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_Z: r_cz     <= i_cfg_data[COORD_W-1:0];
                CFG_RADIUS:   r_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_THRESH:   r_thresh <= i_cfg_data[THRESH_W-1:0];
                default:      r_thresh <= r_thresh;
            endcase
        end
    end

    // shared squarer: one axis per cycle
    always_comb begin
        unique case (w_ctrl.sq_sel)
            AXIS_X: begin
                w_p = r_pt.point_x;
                w_c = r_cx;
            end
            AXIS_Y: begin
                w_p = r_pt.point_y;
                w_c = r_cy;
            end
            default: begin
                w_p = r_pt.point_z;
                w_c = r_cz;
            end
        endcase
        w_d   = {w_p[COORD_W-1], w_p} - {w_c[COORD_W-1], w_c};
        w_mag = w_d[DIFF_W-1] ? DIFF_W'(-w_d) : DIFF_W'(w_d);
        w_sq  = RAD_W'(w_mag) * RAD_W'(w_mag);
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_pt <= i_in_data;
        end
        if (w_ctrl.sq_en) begin
            r_prod <= w_sq;
            r_acc  <= w_ctrl.sq_first ? '0 : (r_acc + r_prod);
        end else if (w_ctrl.sum_en) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // distance to the surface, inlier test and tally
    always_comb begin
        w_rad_ext    = ROOT_W'(r_radius);
        w_dist       = (w_root >= w_rad_ext) ? (w_root - w_rad_ext) : (w_rad_ext - w_root);
        w_inl        = (w_dist < r_thresh);
        w_tally_next = (w_inl && (r_tally < TALLY_CAP)) ? (r_tally + 1'b1) : r_tally;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.finish) begin
                r_tally     <= r_pt.last_point ? '0 : w_tally_next;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            r_out.surface_distance <= w_dist;
            r_out.is_inlier        <= w_inl;
            r_out.inlier_total     <= w_tally_next;
            r_out.end_of_cloud     <= r_pt.last_point;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
